// ----- rtl/bcrf_pkg.sv -----
// Shared constants, types and codes for the bilinear cell row fill block.
package bcrf_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int MAX_SPAN    = 64;

    localparam int WPR         = (MAX_WIDTH + 63) / 64;
    localparam int STORE_DEPTH = MAX_HEIGHT * WPR;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(MAX_SPAN + 1);

    // Shared divider: dividend/divisor width, quotient width, step count width.
    localparam int DIV_W  = 46;
    localparam int DIVQ_W = 23;
    localparam int STEP_W = 5;
    localparam int VAL_STEPS = 17;
    localparam int LIN_STEPS = 23;

    localparam logic FUNC_FILL = 1'b0;
    localparam logic FUNC_MASK = 1'b1;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic [1:0] KIND_MASK  = 2'd0;
    localparam logic [1:0] KIND_EMPTY = 2'd1;
    localparam logic [1:0] KIND_FILL  = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic signed [15:0] tl;
        logic signed [15:0] tr;
        logic signed [15:0] bl;
        logic signed [15:0] br;
        logic signed [11:0] lx;
        logic signed [11:0] y;
        logic [11:0]       span;
        logic [11:0]       hgt;
        logic [11:0]       a_off;
        logic [11:0]       b_off;
        logic [CNT_W-1:0]  cnt;
        logic              clip;
        logic [63:0]       mask_word;
    } t_task;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DIV_W-1:0]  divisor;
        logic [STEP_W-1:0] steps;
    } t_div_cmd;

    typedef struct packed {
        logic              busy;
        logic [DIVQ_W-1:0] quot;
        logic [DIV_W-1:0]  rem;
    } t_div_stat;

    typedef struct packed {
        logic idle;
        logic filling;
    } t_back_stat;

endpackage

// ----- rtl/bcrf_in_if.sv -----
// Input channel: one command beat per fill row or mask word.
interface bcrf_in_if;
    logic               valid;
    logic               ready;
    logic               func;
    logic signed [15:0] corner_tl;
    logic signed [15:0] corner_tr;
    logic signed [15:0] corner_bl;
    logic signed [15:0] corner_br;
    logic signed [11:0] left_x;
    logic signed [11:0] right_x;
    logic signed [11:0] bottom_y;
    logic signed [11:0] top_y;
    logic signed [11:0] row_y;
    logic [63:0]        mask_word;

    modport source (output valid, func, corner_tl, corner_tr, corner_bl, corner_br,
                    left_x, right_x, bottom_y, top_y, row_y, mask_word,
                    input ready);
    modport sink (input valid, func, corner_tl, corner_tr, corner_bl, corner_br,
                  left_x, right_x, bottom_y, top_y, row_y, mask_word,
                  output ready);
endinterface

// ----- rtl/bcrf_out_if.sv -----
// Output channel: one beat per result pixel.
interface bcrf_out_if;
    logic               valid;
    logic               ready;
    logic signed [11:0] pixel_x;
    logic signed [11:0] pixel_y;
    logic signed [15:0] pixel_value;
    logic               write_enable;
    logic               span_clipped;
    logic               last;

    modport source (output valid, pixel_x, pixel_y, pixel_value, write_enable,
                    span_clipped, last, input ready);
    modport sink (input valid, pixel_x, pixel_y, pixel_value, write_enable,
                  span_clipped, last, output ready);
endinterface

// ----- rtl/bilinear_cell_row_fill.sv -----
// Top level of the bilinear cell row fill block: config registers and part wiring.
//
//   channel   dir   handshake          per beat
//   i_in      in    valid/ready        fill row (func 0) or mask word (func 1)
//   o_out     out   valid/ready        one pixel; last marks the end of a row
//   i_cfg_*   in    write enable only  image width (0) or height (1)
//
// A fill row runs its setup products on the shared multiplier; if the first linear
// index is not negative, the shared divider then splits it into row and column, and
// each pixel takes a 17-step divide of the bilinear value and can wait on the output.
// Mask words and empty rows skip the multiplier and divider. Synchronous reset
// clears control only; the mask memory holds nothing until written. The input takes
// beats into a two-entry queue, until it is full, while the back end or output stalls.
module bilinear_cell_row_fill import bcrf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bcrf_in_if.sink     i_in,
    bcrf_out_if.source  o_out,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [10:0] i_cfg_data
);
    logic [10:0] r_img_w;
    logic [10:0] r_img_h;
    t_task       f_task;
    logic        f_valid;
    logic        f_ready;
    t_task       q_task;
    logic        q_valid;
    logic        q_ready;
    t_back_stat  b_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= 11'd1024;
            r_img_h <= 11'd1024;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_WIDTH:  r_img_w <= i_cfg_data;
                REG_HEIGHT: r_img_h <= i_cfg_data;
            endcase
        end
    end

    bcrf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_task  (f_task),
        .o_valid (f_valid),
        .i_ready (f_ready)
    );

    bcrf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_task  (f_task),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .o_task  (q_task),
        .o_valid (q_valid),
        .i_ready (q_ready)
    );

    bcrf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_task  (q_task),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_img_w (r_img_w),
        .i_img_h (r_img_h),
        .o_stat  (b_stat),
        .o_out   (o_out)
    );

    // A pixel that is not the last of its row keeps the back end in the pixel loop.
    a_nonlast_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.last |-> b_stat.filling)
        else $error("non-last pixel pending while back end left the pixel loop");

    // A stalled beat stays on the output unchanged.
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(o_out.pixel_x)
            && $stable(o_out.pixel_value) && $stable(o_out.last))
        else $error("stalled output beat changed or dropped");

    // Stored pixels only exist for a non-empty image.
    a_we_image: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.write_enable |-> (r_img_w != 11'd0) && (r_img_h != 11'd0))
        else $error("write enable set for an empty image");
endmodule

// ----- rtl/bcrf_ram.sv -----
// Generic simple dual-port RAM with registered read.
module bcrf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16384,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic                 i_re,
    input  logic [AW-1:0]        i_raddr,
    output logic [WIDTH-1:0]     o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/bcrf_div.sv -----
// Restoring divider, one quotient bit per cycle, shared by index and value paths.
module bcrf_div import bcrf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_div_cmd  i_cmd,
    output t_div_stat o_stat
);
    logic              r_busy;
    logic [STEP_W-1:0] r_cnt;
    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_ds;
    logic [DIVQ_W-1:0] r_quot;
    logic              ge;

    assign ge = (r_rem >= r_ds);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_cmd.start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_cmd.steps;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == STEP_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_rem  <= i_cmd.dividend;
            r_ds   <= i_cmd.divisor;
            r_quot <= '0;
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= r_rem - r_ds;
            end
            r_quot <= {r_quot[DIVQ_W-2:0], ge};
            r_ds   <= r_ds >> 1;
        end
    end

    assign o_stat = '{busy: r_busy, quot: r_quot, rem: r_rem};
endmodule

// ----- rtl/bcrf_front.sv -----
// Front end: takes input beats and classifies them into mask, empty or fill tasks.
module bcrf_front import bcrf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bcrf_in_if.sink   i_in,
    output t_task     o_task,
    output logic      o_valid,
    input  logic      i_ready
);
    logic               r_valid;
    t_task              r_task;
    t_task              n_task;
    logic signed [12:0] diff;
    logic               is_fill;
    logic               clip;

    assign i_in.ready = !r_valid || i_ready;

    always_comb begin
        diff    = {i_in.right_x[11], i_in.right_x} - {i_in.left_x[11], i_in.left_x};
        is_fill = (diff > 13'sd0) && (i_in.row_y >= i_in.bottom_y)
                  && (i_in.row_y < i_in.top_y);
        clip    = (diff > 13'(MAX_SPAN));

        n_task           = '0;
        n_task.tl        = i_in.corner_tl;
        n_task.tr        = i_in.corner_tr;
        n_task.bl        = i_in.corner_bl;
        n_task.br        = i_in.corner_br;
        n_task.lx        = i_in.left_x;
        n_task.y         = i_in.row_y;
        n_task.mask_word = i_in.mask_word;
        n_task.span      = diff[11:0];
        n_task.hgt       = 12'(i_in.top_y - i_in.bottom_y);
        n_task.a_off     = 12'(i_in.row_y - i_in.bottom_y);
        n_task.b_off     = 12'(i_in.top_y - i_in.row_y);
        n_task.clip      = clip;
        n_task.cnt       = clip ? CNT_W'(MAX_SPAN) : CNT_W'(diff);
        priority if (i_in.func == FUNC_MASK) begin
            n_task.kind = KIND_MASK;
        end else if (is_fill) begin
            n_task.kind = KIND_FILL;
        end else begin
            n_task.kind = KIND_EMPTY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_task <= n_task;
        end
    end

    assign o_task  = r_task;
    assign o_valid = r_valid;
endmodule

// ----- rtl/bcrf_queue.sv -----
// Two-entry task queue between the front end and the back end.
module bcrf_queue import bcrf_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_task i_task,
    input  logic  i_valid,
    output logic  o_ready,
    output t_task o_task,
    output logic  o_valid,
    input  logic  i_ready
);
    t_task      r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       push;
    logic       pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_task  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= !r_wptr;
            end
            if (pop) begin
                r_rptr <= !r_rptr;
            end
            r_count <= r_count + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_task;
        end
    end
endmodule

// ----- rtl/bcrf_back.sv -----
// Back end: mask writes, setup products, per-pixel division, mask lookup and output.
module bcrf_back import bcrf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_task       i_task,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [10:0] i_img_w,
    input  logic [10:0] i_img_h,
    output t_back_stat  o_stat,
    bcrf_out_if.source  o_out
);
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MASK  = 3'd1;
    localparam logic [2:0] ST_EMPTY = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_LDIV  = 3'd4;
    localparam logic [2:0] ST_PIX   = 3'd5;
    localparam logic [2:0] ST_PIX2  = 3'd6;
    localparam logic [2:0] ST_VDIV  = 3'd7;

    logic [2:0]         r_state;
    logic [3:0]         r_mstep;
    t_task              r_t;
    logic signed [29:0] r_p;
    logic signed [29:0] r_q;
    logic signed [30:0] r_d;
    logic signed [43:0] r_s;
    logic [23:0]        r_area;
    logic signed [23:0] r_lin;
    logic [21:0]        r_total;
    logic [22:0]        r_row;
    logic [10:0]        r_col;
    logic signed [11:0] r_x;
    logic [CNT_W-1:0]   r_k;
    logic signed [45:0] r_num;
    logic               r_inb;
    logic               r_mok;

    logic               r_ovalid;
    logic signed [11:0] r_ox;
    logic signed [11:0] r_oy;
    logic signed [15:0] r_oval;
    logic               r_owe;
    logic               r_oclip;
    logic               r_olast;

    logic signed [30:0] m_a;
    logic signed [12:0] m_b;
    logic signed [43:0] m_p;
    t_div_cmd           div_cmd;
    t_div_stat          div_st;
    logic [63:0]        rd_word;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [ADDR_W-1:0]  ram_raddr;
    logic               ram_re;
    logic               out_free;
    logic               out_load;
    logic               is_last;
    logic signed [17:0] vfull;
    logic signed [15:0] vsat;
    logic [45:0]        num_abs;

    assign out_free = !r_ovalid || o_out.ready;
    assign out_load = out_free && ((r_state == ST_EMPTY)
                                   || ((r_state == ST_VDIV) && !div_st.busy));
    assign o_ready  = (r_state == ST_IDLE);
    assign is_last  = (r_k == r_t.cnt - 1'b1);
    assign o_stat   = '{idle: (r_state == ST_IDLE),
                        filling: (r_state == ST_PIX) || (r_state == ST_PIX2)
                                 || (r_state == ST_VDIV)};

    // Shared setup multiplier.
    always_comb begin
        m_a = '0;
        m_b = '0;
        unique case (r_mstep)
            4'd0: begin
                m_a = 31'(r_t.tl);
                m_b = $signed({1'b0, r_t.a_off});
            end
            4'd1: begin
                m_a = 31'(r_t.bl);
                m_b = $signed({1'b0, r_t.b_off});
            end
            4'd2: begin
                m_a = 31'(r_t.tr);
                m_b = $signed({1'b0, r_t.a_off});
            end
            4'd3: begin
                m_a = 31'(r_t.br);
                m_b = $signed({1'b0, r_t.b_off});
            end
            4'd4: begin
                m_a = 31'(r_p);
                m_b = $signed({1'b0, r_t.span});
            end
            4'd5: begin
                m_a = $signed({19'b0, r_t.span});
                m_b = $signed({1'b0, r_t.hgt});
            end
            4'd6: begin
                m_a = 31'(r_t.y);
                m_b = $signed({2'b0, i_img_w});
            end
            4'd7: begin
                m_a = $signed({20'b0, i_img_w});
                m_b = $signed({2'b0, i_img_h});
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
        m_p = m_a * m_b;
    end

    // Value: sign of the rounded numerator applied to the quotient magnitude, saturated to 16 bits.
    always_comb begin
        vfull = r_num[45] ? -$signed({1'b0, div_st.quot[16:0]})
                          : $signed({1'b0, div_st.quot[16:0]});
        priority if (vfull > 18'sd32767) begin
            vsat = 16'sh7FFF;
        end else if (vfull < -18'sd32768) begin
            vsat = -16'sh8000;
        end else begin
            vsat = vfull[15:0];
        end
        num_abs = r_num[45] ? 46'(-r_num) : 46'(r_num);
    end

    always_comb begin
        div_cmd = '0;
        if (r_state == ST_MUL && r_mstep == 4'd8 && !r_lin[23]) begin
            div_cmd.start    = 1'b1;
            div_cmd.dividend = DIV_W'(r_lin[22:0]);
            div_cmd.divisor  = DIV_W'(i_img_w) << (LIN_STEPS - 1);
            div_cmd.steps    = STEP_W'(LIN_STEPS);
        end else if (r_state == ST_PIX2) begin
            div_cmd.start    = 1'b1;
            div_cmd.dividend = num_abs;
            div_cmd.divisor  = DIV_W'({r_area, 1'b0}) << (VAL_STEPS - 1);
            div_cmd.steps    = STEP_W'(VAL_STEPS);
        end
    end

    assign ram_we    = (r_state == ST_MASK) && (r_t.lx >= 12'sd0)
                       && (32'(r_t.lx) < WPR) && (r_t.y >= 12'sd0)
                       && (32'(r_t.y) < MAX_HEIGHT);
    assign ram_waddr = ADDR_W'(ADDR_W'(r_t.y) * ADDR_W'(WPR) + ADDR_W'(r_t.lx));
    assign ram_re    = (r_state == ST_PIX);
    assign ram_raddr = ADDR_W'(ADDR_W'(r_row) * ADDR_W'(WPR) + ADDR_W'(r_col >> 6));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_mstep  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    r_mstep <= '0;
                    if (i_valid) begin
                        unique case (i_task.kind)
                            KIND_MASK:  r_state <= ST_MASK;
                            KIND_EMPTY: r_state <= ST_EMPTY;
                            default:    r_state <= ST_MUL;
                        endcase
                    end
                end
                ST_MASK: begin
                    r_state <= ST_IDLE;
                end
                ST_EMPTY: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_MUL: begin
                    r_mstep <= r_mstep + 1'b1;
                    if (r_mstep == 4'd8) begin
                        r_state <= r_lin[23] ? ST_PIX : ST_LDIV;
                    end
                end
                ST_LDIV: begin
                    if (!div_st.busy) begin
                        r_state <= ST_PIX;
                    end
                end
                ST_PIX: begin
                    r_state <= ST_PIX2;
                end
                ST_PIX2: begin
                    r_state <= ST_VDIV;
                end
                ST_VDIV: begin
                    if (!div_st.busy && out_free) begin
                        r_state <= is_last ? ST_IDLE : ST_PIX;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    r_t <= i_task;
                end
            end
            ST_EMPTY: begin
                if (out_free) begin
                    r_ox    <= r_t.lx;
                    r_oy    <= r_t.y;
                    r_oval  <= '0;
                    r_owe   <= 1'b0;
                    r_oclip <= 1'b0;
                    r_olast <= 1'b1;
                end
            end
            ST_MUL: begin
                unique case (r_mstep)
                    4'd0: r_p <= m_p[29:0];
                    4'd1: r_p <= r_p + m_p[29:0];
                    4'd2: r_q <= m_p[29:0];
                    4'd3: r_q <= r_q + m_p[29:0];
                    4'd4: r_s <= m_p;
                    4'd5: begin
                        r_area <= m_p[23:0];
                        r_d    <= {r_q[29], r_q} - {r_p[29], r_p};
                    end
                    4'd6: r_lin <= m_p[23:0] + {{12{r_t.lx[11]}}, r_t.lx};
                    4'd7: r_total <= m_p[21:0];
                    default: begin
                        // Rows and columns start at zero while the index is negative.
                        r_row <= '0;
                        r_col <= '0;
                        r_x   <= r_t.lx;
                        r_k   <= '0;
                    end
                endcase
            end
            ST_LDIV: begin
                if (!div_st.busy) begin
                    r_row <= div_st.quot;
                    r_col <= div_st.rem[10:0];
                end
            end
            ST_PIX: begin
                r_num <= {r_s[43], r_s, 1'b0} + {22'b0, r_area};
                r_inb <= !r_lin[23] && (r_lin < $signed({2'b00, r_total}));
                r_mok <= (32'(r_row) < MAX_HEIGHT) && (32'(r_col) < WPR * 64);
            end
            ST_VDIV: begin
                if (!div_st.busy && out_free) begin
                    r_ox    <= r_x;
                    r_oy    <= r_t.y;
                    r_oval  <= vsat;
                    r_owe   <= r_inb && r_mok && rd_word[r_col[5:0]];
                    r_oclip <= r_t.clip;
                    r_olast <= is_last;
                    r_s     <= r_s + {{13{r_d[30]}}, r_d};
                    r_x     <= r_x + 12'sd1;
                    r_k     <= r_k + 1'b1;
                    r_lin   <= r_lin + 24'sd1;
                    if (!r_lin[23]) begin
                        if ({1'b0, r_col} + 12'd1 == {1'b0, i_img_w}) begin
                            r_col <= '0;
                            r_row <= r_row + 1'b1;
                        end else begin
                            r_col <= r_col + 1'b1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    bcrf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (div_cmd),
        .o_stat  (div_st)
    );

    bcrf_ram #(.WIDTH(64), .DEPTH(STORE_DEPTH)) u_mask (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_t.mask_word),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (rd_word)
    );

    assign o_out.valid        = r_ovalid;
    assign o_out.pixel_x      = r_ox;
    assign o_out.pixel_y      = r_oy;
    assign o_out.pixel_value  = r_oval;
    assign o_out.write_enable = r_owe;
    assign o_out.span_clipped = r_oclip;
    assign o_out.last         = r_olast;
endmodule

// ----- tb/bilinear_cell_row_fill_test.sv -----
// Self-checking testbench for the bilinear cell row fill block: directed table, then random rows.
module bilinear_cell_row_fill_test;
    import bcrf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 100;
    localparam int ITEMS_PER_PHASE = 45;

    typedef struct {
        logic               func;
        logic signed [15:0] tl, tr, bl, br;
        logic signed [11:0] lx, rx, by, ty, y;
        logic [63:0]        word;
    } t_cmd;

    typedef struct {
        logic signed [11:0] x, y;
        logic signed [15:0] value;
        logic               we, clip, last;
    } t_pix;

    typedef struct {
        t_cmd cmd;
        bit   typed;
        t_pix pix;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_idx;
    logic [10:0] i_cfg_data;

    bcrf_in_if  in_ch ();
    bcrf_out_if out_ch ();

    bilinear_cell_row_fill u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow state of the block.
    logic [10:0] img_w, img_h;
    logic [63:0] mask_mem [STORE_DEPTH];
    bit          mask_known [STORE_DEPTH];
    t_pix        pending_pixels [$];

    int src_idle_pct, snk_idle_pct;
    int errors, rows_sent, masks_sent, pixels_seen, idle_cycles;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Computes the pixels of one fill row. Pushes them when emit is set; returns 1 if any
    // in-bounds pixel would look up a mask word that was never written.
    function automatic bit fill_row(t_cmd c, bit emit);
        longint tl, tr, bl, br, lx, rx, by, ty, y;
        longint span, n, area, total, x, s, v, lin, row, col, w;
        int     idx;
        bit     unsafe;
        t_pix   p;
        tl = c.tl; tr = c.tr; bl = c.bl; br = c.br;
        lx = c.lx; rx = c.rx; by = c.by; ty = c.ty; y = c.y;
        w = img_w;
        unsafe = 0;
        if (rx <= lx || y < by || y >= ty) begin
            p = '{x: c.lx, y: c.y, value: '0, we: 1'b0, clip: 1'b0, last: 1'b1};
            if (emit) pending_pixels.push_back(p);
            return 0;
        end
        span = rx - lx;
        n = (span > MAX_SPAN) ? MAX_SPAN : span;
        area = span * (ty - by);
        total = w * longint'(img_h);
        for (longint k = 0; k < n; k++) begin
            x = lx + k;
            s = tl * (rx - x) * (y - by) + tr * (x - lx) * (y - by)
              + bl * (rx - x) * (ty - y) + br * (x - lx) * (ty - y);
            v = (2 * s + area) / (2 * area);
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            lin = x + y * w;
            p.we = 1'b0;
            if (lin >= 0 && lin < total) begin
                row = lin / w;
                col = lin % w;
                if (row < MAX_HEIGHT && col < WPR * 64) begin
                    idx = int'(row * WPR + col / 64);
                    if (!mask_known[idx]) unsafe = 1;
                    p.we = mask_mem[idx][col % 64];
                end
            end
            p.x = x[11:0];
            p.y = c.y;
            p.value = v[15:0];
            p.clip = (span > MAX_SPAN);
            p.last = (k == n - 1);
            if (emit) pending_pixels.push_back(p);
        end
        return unsafe;
    endfunction

    function automatic t_cmd mk_fill(int tl, int tr, int bl, int br, int lx, int rx,
                                     int by, int ty, int y);
        t_cmd c;
        c.func = FUNC_FILL;
        c.tl = tl[15:0]; c.tr = tr[15:0]; c.bl = bl[15:0]; c.br = br[15:0];
        c.lx = lx[11:0]; c.rx = rx[11:0]; c.by = by[11:0]; c.ty = ty[11:0];
        c.y = y[11:0];
        c.word = {$urandom, $urandom};
        return c;
    endfunction

    function automatic t_cmd mk_mask(int word_idx, int row, logic [63:0] bits);
        t_cmd c;
        c = mk_fill($urandom, $urandom, $urandom, $urandom, word_idx, $urandom,
                    $urandom, $urandom, row);
        c.func = FUNC_MASK;
        c.word = bits;
        return c;
    endfunction

    function automatic int rand_corner();
        case ($urandom_range(5))
            0: return 32767;
            1: return -32768;
            default: return int'($urandom_range(65535)) - 32768;
        endcase
    endfunction

    function automatic t_cmd rand_cmd();
        t_cmd c;
        int   y, by, ty, lx, rx;
        if ($urandom_range(99) < 15) begin
            y = ($urandom_range(9) == 0) ? int'($urandom_range(4095)) - 2048
                                         : int'($urandom_range(31));
            lx = ($urandom_range(9) == 0) ? int'($urandom_range(4095)) - 2048
                                          : int'($urandom_range(17)) - 1;
            return mk_mask(lx, y, {$urandom, $urandom});
        end
        do begin
            y = ($urandom_range(99) < 85) ? int'($urandom_range(7))
                                          : int'($urandom_range(4095)) - 2048;
            if ($urandom_range(9) == 0) begin
                by = int'($urandom_range(4095)) - 2048;
                ty = int'($urandom_range(4095)) - 2048;
            end else begin
                by = y - int'($urandom_range(20));
                ty = y + 1 + int'($urandom_range(20));
            end
            lx = int'($urandom_range(1100)) - 60;
            case ($urandom_range(29))
                0: begin
                    lx = int'($urandom_range(4095)) - 2048;
                    rx = int'($urandom_range(4095)) - 2048;
                end
                1, 2, 3: rx = lx + int'($urandom_range(130));
                default: rx = lx + 1 + int'($urandom_range(15));
            endcase
            c = mk_fill(rand_corner(), rand_corner(), rand_corner(), rand_corner(),
                        lx, rx, by, ty, y);
        end while (fill_row(c, 0));
        return c;
    endfunction

    task automatic send_beat(t_cmd c, bit typed, t_pix p);
        int idx;
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.func = c.func;
        in_ch.corner_tl = c.tl; in_ch.corner_tr = c.tr;
        in_ch.corner_bl = c.bl; in_ch.corner_br = c.br;
        in_ch.left_x = c.lx; in_ch.right_x = c.rx;
        in_ch.bottom_y = c.by; in_ch.top_y = c.ty;
        in_ch.row_y = c.y;
        in_ch.mask_word = c.word;
        in_ch.valid = 1'b1;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        if (c.func == FUNC_MASK) begin
            masks_sent++;
            if (c.lx >= 0 && c.lx < WPR && c.y >= 0 && c.y < MAX_HEIGHT) begin
                idx = int'(c.y) * WPR + int'(c.lx);
                mask_mem[idx] = c.word;
                mask_known[idx] = 1;
            end
        end else begin
            rows_sent++;
            if (typed) pending_pixels.push_back(p);
            else void'(fill_row(c, 1));
        end
        @(negedge i_clk);
    endtask

    // Waits until every expected pixel has arrived, then lets the back end settle.
    task automatic drain();
        in_ch.valid = 1'b0;
        while (pending_pixels.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [10:0] value);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == REG_WIDTH) img_w = value;
        else img_h = value;
    endtask

    task automatic check_field(string name, longint expv, longint actv);
        if (expv != actv) begin
            $error("%s mismatch: expected %0d, got %0d", name, expv, actv);
            errors++;
        end
    endtask

    always @(negedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge i_clk) begin
        t_pix e;
        if (out_ch.valid && out_ch.ready) begin
            pixels_seen++;
            if (pending_pixels.size() == 0) begin
                $error("unexpected pixel beat at x=%0d y=%0d", out_ch.pixel_x, out_ch.pixel_y);
                errors++;
            end else begin
                e = pending_pixels.pop_front();
                check_field("pixel_x", e.x, out_ch.pixel_x);
                check_field("pixel_y", e.y, out_ch.pixel_y);
                check_field("pixel_value", e.value, out_ch.pixel_value);
                check_field("write_enable", e.we, out_ch.write_enable);
                check_field("span_clipped", e.clip, out_ch.span_clipped);
                check_field("last", e.last, out_ch.last);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Timeout: no beat accepted for %0d cycles", STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_row        dir_tab [$];
        t_pix        none;
        int          cfg_w [7];
        int          cfg_h [7];
        logic [63:0] word;
        none = '{x: '0, y: '0, value: '0, we: 1'b0, clip: 1'b0, last: 1'b0};
        cfg_w = '{1024, 1, 2047, 0, 64, 100, 1 + $urandom_range(1023)};
        cfg_h = '{1024, 1, 2047, 5, 8, 3, 1 + $urandom_range(1023)};
        errors = 0; rows_sent = 0; masks_sent = 0; pixels_seen = 0; idle_cycles = 0;
        src_idle_pct = 33;
        snk_idle_pct = 49;
        img_w = 11'd1024;
        img_h = 11'd1024;
        foreach (mask_known[i]) mask_known[i] = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_WIDTH;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.func = FUNC_FILL;
        in_ch.corner_tl = '0; in_ch.corner_tr = '0;
        in_ch.corner_bl = '0; in_ch.corner_br = '0;
        in_ch.left_x = '0; in_ch.right_x = '0;
        in_ch.bottom_y = '0; in_ch.top_y = '0;
        in_ch.row_y = '0;
        in_ch.mask_word = '0;
        out_ch.ready = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Give rows 0 to 7 a defined mask so in-bounds lookups there are legal.
        for (int r = 0; r < 8; r++) begin
            for (int wd = 0; wd < WPR; wd++) begin
                word = (r == 0 && wd == 0) ? '1 : (r == 0 && wd == 1) ? '0
                                                 : {$urandom, $urandom};
                send_beat(mk_mask(wd, r, word), 0, none);
            end
        end

        // Empty spans carry a result that is known without arithmetic.
        dir_tab.push_back('{mk_fill(1, 2, 3, 4, 5, 5, 0, 4, 2), 1,
                            '{x: 12'sd5, y: 12'sd2, value: '0, we: 0, clip: 0, last: 1}});
        dir_tab.push_back('{mk_fill(1, 2, 3, 4, 2047, -2048, 0, 4, 2), 1,
                            '{x: 12'sd2047, y: 12'sd2, value: '0, we: 0, clip: 0, last: 1}});
        dir_tab.push_back('{mk_fill(1, 2, 3, 4, 0, 8, 3, 9, 2), 1,
                            '{x: 12'sd0, y: 12'sd2, value: '0, we: 0, clip: 0, last: 1}});
        dir_tab.push_back('{mk_fill(1, 2, 3, 4, 0, 8, 0, 4, 4), 1,
                            '{x: 12'sd0, y: 12'sd4, value: '0, we: 0, clip: 0, last: 1}});
        dir_tab.push_back('{mk_fill(1, 2, 3, 4, -2048, 2047, -2048, 2047, 2047), 1,
                            '{x: -12'sd2048, y: 12'sd2047, value: '0, we: 0, clip: 0,
                              last: 1}});
        // Corner extremes, saturation and mixed signs.
        dir_tab.push_back('{mk_fill(32767, 32767, 32767, 32767, 0, 4, 0, 4, 1), 0, none});
        dir_tab.push_back('{mk_fill(-32768, -32768, -32768, -32768, 0, 4, 0, 4, 1), 0, none});
        dir_tab.push_back('{mk_fill(32767, -32768, -32768, 32767, 60, 70, 0, 8, 0), 0, none});
        dir_tab.push_back('{mk_fill(-32768, 32767, 0, -1, 0, 3, -5, 3, 2), 0, none});
        // Span lengths around the clip point, and a clipped span out of bounds.
        dir_tab.push_back('{mk_fill(100, -200, 300, -400, 0, 64, 0, 8, 3), 0, none});
        dir_tab.push_back('{mk_fill(100, -200, 300, -400, 0, 65, 0, 8, 3), 0, none});
        dir_tab.push_back('{mk_fill(7, 9, -11, 13, -10, 100, 0, 8, 3), 0, none});
        dir_tab.push_back('{mk_fill(5, 6, 7, 8, -2048, 2047, -2048, 2047, 0), 0, none});
        // Columns off the row edge wrap into the neighbouring row.
        dir_tab.push_back('{mk_fill(1000, 2000, 3000, 4000, -3, 5, 0, 4, 2), 0, none});
        dir_tab.push_back('{mk_fill(1000, 2000, 3000, 4000, 1020, 1030, 0, 8, 6), 0, none});
        dir_tab.push_back('{mk_fill(-5, 5, -5, 5, 1024, 1040, -4, 2, -1), 0, none});
        // Mask writes: a far corner word, then indexes that must be ignored.
        dir_tab.push_back('{mk_mask(WPR - 1, MAX_HEIGHT - 1, '1), 0, none});
        dir_tab.push_back('{mk_mask(WPR, 3, '0), 0, none});
        dir_tab.push_back('{mk_mask(2, -1, '0), 0, none});
        dir_tab.push_back('{mk_mask(-2048, MAX_HEIGHT, '0), 0, none});
        dir_tab.push_back('{mk_fill(11, 22, 33, 44, 1000, 1024, 1020, 1024, 1023), 0, none});
        dir_tab.push_back('{mk_fill(-1, 1, -1, 1, 0, 40, 0, 1, 0), 0, none});
        foreach (dir_tab[i]) send_beat(dir_tab[i].cmd, dir_tab[i].typed, dir_tab[i].pix);

        for (int ph = 0; ph < 7; ph++) begin
            drain();
            if (ph >= 4) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end else if (ph >= 2) begin
                src_idle_pct = 49;
                snk_idle_pct = 33;
            end
            write_reg(REG_WIDTH, cfg_w[ph][10:0]);
            write_reg(REG_HEIGHT, cfg_h[ph][10:0]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) send_beat(rand_cmd(), 0, none);
        end
        in_ch.valid = 1'b0;

        while (pending_pixels.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        $display("Covered %0d fill rows and %0d mask writes, %0d pixel beats checked,",
                 rows_sent, masks_sent, pixels_seen);
        $display("over 7 image size settings and three sender/receiver idle mixes.");
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/bcrf_pkg.sv
rtl/bcrf_in_if.sv
rtl/bcrf_out_if.sv
rtl/bcrf_ram.sv
rtl/bcrf_div.sv
rtl/bcrf_front.sv
rtl/bcrf_queue.sv
rtl/bcrf_back.sv
rtl/bilinear_cell_row_fill.sv
tb/bilinear_cell_row_fill_test.sv
